// ===== sv/otrd_pkg.sv =====
// otrd_pkg: shared types, constants and address helpers for the octal tree
// route decider. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package otrd_pkg;

  localparam int ADDR_BYTES = 5;
  localparam int DIGIT_W    = 3;
  localparam int NODE_W     = DIGIT_W * ADDR_BYTES;
  localparam int BYTE_W     = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [BYTE_W-1:0]  FILL_BYTE  = 8'hCC;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 3'd7;

  // Register map (word index)
  localparam logic REG_OWN_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    MSG_DATA  = 2'd0,
    MSG_ACK   = 2'd1,
    MSG_OTHER = 2'd2,
    MSG_THREE = 2'd3
  } pkt_type_t;

  typedef enum logic [2:0] {
    ACT_TRANSMIT  = 3'd0,
    ACT_DELIVER   = 3'd1,
    ACT_ACK_NOTED = 3'd2,
    ACT_FORWARD   = 3'd3,
    ACT_IGNORE    = 3'd4
  } action_t;

  localparam logic FUNC_SEND = 1'b0;

  typedef struct packed {
    logic [ADDR_BYTES-1:0][BYTE_W-1:0] bytes;
    logic                              bad;
  } hop_addr_t;

  function automatic logic [BYTE_W-1:0] pool_byte(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] b;
    case (d)
      3'd0:    b = 8'hc3;
      3'd1:    b = 8'h3c;
      3'd2:    b = 8'h33;
      3'd3:    b = 8'hce;
      3'd4:    b = 8'h3e;
      3'd5:    b = 8'he3;
      3'd6:    b = 8'hec;
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

  // Covers every digit up to and including the highest non-zero one.
  function automatic logic [NODE_W-1:0] digit_mask(input logic [NODE_W-1:0] addr);
    logic [NODE_W-1:0] m;
    logic              any;
    m   = '0;
    any = 1'b0;
    for (int k = ADDR_BYTES - 1; k >= 0; k--) begin
      any = any | (addr[DIGIT_W*k +: DIGIT_W] != '0);
      m[DIGIT_W*k +: DIGIT_W] = {DIGIT_W{any}};
    end
    return m;
  endfunction

  // Child on the path when dest descends from own, else the parent.
  function automatic logic [NODE_W-1:0] route_toward(input logic [NODE_W-1:0] own,
                                                     input logic [NODE_W-1:0] dest);
    logic [NODE_W-1:0] nm;
    logic [NODE_W-1:0] r;
    nm = digit_mask(own);
    if ((dest & nm) == own) begin
      r = dest & {nm[NODE_W-DIGIT_W-1:0], {DIGIT_W{1'b1}}};
    end else begin
      r = (nm >> DIGIT_W) & own;
    end
    return r;
  endfunction

endpackage

// ===== sv/octal_tree_route_decider.sv =====
// octal_tree_route_decider: top level; APB register, input register, route
// decision and result register. Depends on otrd_pkg and otrd_hop_encode.
`timescale 1ns / 1ps
// One header transaction is taken at every clock edge with start high and
// busy low; busy stays low, so a header can be issued every cycle. Its result
// is loaded into the result register at the edge after acceptance (input
// register, then result register) and is marked on the result ports by done
// for exactly one cycle. There is no backpressure: the receiver must take
// each result in the cycle it is shown. The decision is a pure function of
// the header and own_address, so throughput is one transaction per cycle.
// own_address sits at APB byte address 0 (reset 0) and should only be
// written while no header is in flight.
module octal_tree_route_decider
  import otrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // header command
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [NODE_W-1:0] dest_addr,
  input  logic [NODE_W-1:0] src_node,
  input  logic [1:0]        pkt_type,
  // result
  output logic              done,
  output logic [2:0]        action,
  output logic [NODE_W-1:0] hop_node,
  output logic [BYTE_W-1:0] hop_byte0,
  output logic [BYTE_W-1:0] hop_byte1,
  output logic [BYTE_W-1:0] hop_byte2,
  output logic [BYTE_W-1:0] hop_byte3,
  output logic [BYTE_W-1:0] hop_byte4,
  output logic [NODE_W-1:0] out_to_node,
  output logic [NODE_W-1:0] out_from_node,
  output logic [1:0]        out_type,
  output logic              bad_address
);

  // ---------------- configuration ----------------
  logic [NODE_W-1:0] own_address;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_OWN_ADDRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      own_address <= pwdata[NODE_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(APB_DW-NODE_W){1'b0}}, own_address} : '0;

  // ---------------- input register ----------------
  // Never stalls: results cannot be held off, so nothing backs up.
  assign busy = 1'b0;

  logic              s1_valid;
  logic              s1_func;
  logic [NODE_W-1:0] s1_dest;
  logic [NODE_W-1:0] s1_src;
  logic [1:0]        s1_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_func <= func;
      s1_dest <= dest_addr;
      s1_src  <= src_node;
      s1_type <= pkt_type;
    end
  end

  // ---------------- route decision ----------------
  action_t           action_next;
  logic [NODE_W-1:0] hop_next;
  logic [NODE_W-1:0] to_next;
  logic [NODE_W-1:0] from_next;
  logic [1:0]        type_next;
  logic [NODE_W-1:0] target;
  hop_addr_t         hop_addr;

  always_comb begin
    action_next = ACT_IGNORE;
    target      = s1_dest;
    to_next     = '0;
    from_next   = '0;
    type_next   = '0;
    hop_next    = '0;
    if (s1_func == FUNC_SEND) begin
      action_next = ACT_TRANSMIT;
      to_next     = s1_dest;
      from_next   = own_address;
      type_next   = s1_type;
    end else if (s1_dest == own_address) begin
      // addressed to us: only data gets a reply (ack back to the source)
      case (s1_type)
        MSG_DATA: begin
          action_next = ACT_DELIVER;
          target      = s1_src;
          to_next     = s1_src;
          from_next   = own_address;
          type_next   = MSG_ACK;
        end
        MSG_ACK:  action_next = ACT_ACK_NOTED;
        default:  action_next = ACT_IGNORE;
      endcase
    end else begin
      // pass-through: header copied unchanged
      action_next = ACT_FORWARD;
      to_next     = s1_dest;
      from_next   = s1_src;
      type_next   = s1_type;
    end
    // non-sending outcomes report hop node 0
    if (action_next != ACT_ACK_NOTED && action_next != ACT_IGNORE) begin
      hop_next = route_toward(own_address, target);
    end
  end

  otrd_hop_encode u_hop_encode (
    .hop_node (hop_next),
    .hop_addr (hop_addr)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      action        <= action_next;
      hop_node      <= hop_next;
      hop_byte0     <= hop_addr.bytes[0];
      hop_byte1     <= hop_addr.bytes[1];
      hop_byte2     <= hop_addr.bytes[2];
      hop_byte3     <= hop_addr.bytes[3];
      hop_byte4     <= hop_addr.bytes[4];
      out_to_node   <= to_next;
      out_from_node <= from_next;
      out_type      <= type_next;
      bad_address   <= hop_addr.bad;
    end
  end

  // ---------------- assertions ----------------
  a_accept_to_stage: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !rst) |=> s1_valid)
    else $error("accepted header did not reach the input register");

  a_done_from_stage: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result strobe without a staged header");

  a_quiet_no_hop: assert property (@(posedge clk) disable iff (rst)
    (done && (action == ACT_ACK_NOTED || action == ACT_IGNORE)) |->
      (hop_node == '0 && !bad_address && hop_byte0 == FILL_BYTE &&
       hop_byte4 == FILL_BYTE && out_to_node == '0))
    else $error("non-sending result carries a hop");

  a_deliver_acks: assert property (@(posedge clk) disable iff (rst)
    (done && action == ACT_DELIVER) |-> (out_type == MSG_ACK && out_from_node == own_address))
    else $error("delivery reply header malformed");

endmodule

// ===== sv/otrd_hop_encode.sv =====
// otrd_hop_encode: maps a hop node address to its five radio address bytes
// and flags a digit without a pool entry. Depends on otrd_pkg.
`timescale 1ns / 1ps
module otrd_hop_encode
  import otrd_pkg::*;
(
  input  logic [NODE_W-1:0] hop_node,
  output hop_addr_t         hop_addr
);

  always_comb begin
    logic [NODE_W-1:0]  rem;
    logic [DIGIT_W-1:0] d;
    hop_addr.bad = 1'b0;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      rem = hop_node >> (DIGIT_W * i);
      d   = rem[DIGIT_W-1:0];
      if (rem == '0) begin
        hop_addr.bytes[i] = FILL_BYTE;
      end else begin
        hop_addr.bytes[i] = pool_byte(d);
        if (d == DIGIT_NONE) begin
          hop_addr.bad = 1'b1;
        end
      end
    end
  end

endmodule
